/* hw/rtl/fsv_pkg.sv */
`default_nettype none

package fsv_pkg;

   // Field widths of the channels and the configuration port.
   localparam int DATA_WIDTH     = 64;
   localparam int MOD_WIDTH      = 64;
   localparam int SUM_WIDTH      = MOD_WIDTH + 2;
   localparam int ROUND_WIDTH    = 6;
   localparam int CMD_WIDTH      = 2;
   localparam int CNT_WIDTH      = $clog2(DATA_WIDTH);
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_LSB  = 3;

   localparam logic [ROUND_WIDTH-1:0] ROUNDS_MIN = ROUND_WIDTH'(3);
   localparam logic [ROUND_WIDTH-1:0] ROUNDS_MAX = ROUND_WIDTH'(50);

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET    = MOD_WIDTH'(2);
   localparam logic [MOD_WIDTH-1:0] PUBLIC_KEY_RESET = MOD_WIDTH'(1);

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_QUESTION = 2'd0,
      CMD_VERIFY   = 2'd1,
      CMD_CHECK    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_ADDR_WIDTH-CSR_INDEX_LSB-1:0] {
      CSR_MODULUS     = 2'd0,
      CSR_PUBLIC_KEY  = 2'd1,
      CSR_ROUND_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_KEY,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/fsv_channels.sv */
`default_nettype none

interface fsv_req_if;
   logic                             valid;
   logic                             ready;
   logic [fsv_pkg::CMD_WIDTH-1:0]    command;
   logic [fsv_pkg::DATA_WIDTH-1:0]   commitment;
   logic                             challenge_bit;
   logic [fsv_pkg::DATA_WIDTH-1:0]   response;

   modport source (output valid, command, commitment, challenge_bit, response,
                   input ready);
   modport sink   (input valid, command, commitment, challenge_bit, response,
                   output ready);
endinterface

interface fsv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             success;
   logic                             challenge_out;
   logic [fsv_pkg::ROUND_WIDTH-1:0]  rounds_left;

   modport source (output valid, success, challenge_out, rounds_left,
                   input ready);
   modport sink   (input valid, success, challenge_out, rounds_left,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/fiat_shamir_verifier.sv */
`default_nettype none

// Verifier for Fiat-Shamir identification rounds. A question beat stores the
// commitment and the challenge bit; a verify beat tests the response against
// the stored pair, and a check beat carries all three at once. The test
// y*y (times the public key when the bit is set) mod n is computed by one
// shared modular shift-add unit that takes one bit of the multiplier per
// cycle: a first pass reduces y modulo n, a second squares it and a
// third multiplies by the key when the bit is one. A check state then
// records the result and a done state moves it to the response register
// once that register is free; only then is the next request taken. Questions
// and refused commands go straight from idle to the done state. A
// finished response waits in its output register, so the next
// request is taken while it is still unread. Configuration registers sit at
// byte addresses 0 (modulus), 8 (public key) and 16 (round count) and may only
// be written while the block is idle; a write to any of the three reloads
// the round counter. No clearing pass follows reset.
module fiat_shamir_verifier (
   input  wire                                 clock,
   input  wire                                 reset,
   fsv_req_if.sink                             req_chan,
   fsv_rsp_if.source                           rsp_chan,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [fsv_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire [fsv_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [fsv_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   typedef struct packed {
      logic unit_start;
      logic unit_step;
      logic chain_square;
      logic chain_key;
      logic check_en;
      logic post;
   } seq_ctl_type;

   // Configuration and protocol state.
   logic [fsv_pkg::MOD_WIDTH-1:0]    modulus_ff;
   logic [fsv_pkg::MOD_WIDTH-1:0]    public_key_ff;
   logic [fsv_pkg::ROUND_WIDTH-1:0]  round_count_ff;
   logic [fsv_pkg::ROUND_WIDTH-1:0]  rounds_ff;
   logic [fsv_pkg::DATA_WIDTH-1:0]   stored_commitment_ff;
   logic                             stored_challenge_ff;
   logic                             pending_ff;

   fsv_pkg::state_type state_ff, state_in;
   seq_ctl_type        ctl;

   // Operands of the current test.
   logic [fsv_pkg::DATA_WIDTH-1:0]   x_ff;
   logic                             bit_ff;
   logic [fsv_pkg::DATA_WIDTH-1:0]   y_ff;

   // Shared modular multiply unit.
   logic [fsv_pkg::MOD_WIDTH-1:0]    acc_ff;
   logic [fsv_pkg::MOD_WIDTH-1:0]    mult_a_ff;
   logic [fsv_pkg::DATA_WIDTH-1:0]   mult_b_ff;
   logic [fsv_pkg::CNT_WIDTH-1:0]    cnt_ff;
   logic [fsv_pkg::SUM_WIDTH-1:0]    sum_raw;
   logic [fsv_pkg::SUM_WIDTH-1:0]    mod_once;
   logic [fsv_pkg::SUM_WIDTH-1:0]    mod_twice;
   logic [fsv_pkg::MOD_WIDTH-1:0]    step_sum;
   logic                             last_bit;

   // Pending result and output register.
   logic                             res_ok_ff;
   logic                             res_chal_ff;
   logic [fsv_pkg::ROUND_WIDTH-1:0]  res_left_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_success_ff;
   logic                             rsp_chal_ff;
   logic [fsv_pkg::ROUND_WIDTH-1:0]  rsp_left_ff;

   logic                             req_fire;
   logic                             is_question;
   logic                             is_verify;
   logic                             is_check;
   logic                             go_test;
   logic                             test_pass;
   logic                             out_free;

   logic                             csr_write;
   fsv_pkg::csr_index_type           csr_index;
   logic [fsv_pkg::ROUND_WIDTH-1:0]  round_wr;
   logic [fsv_pkg::MOD_WIDTH-1:0]    modulus_wr;

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   assign req_chan.ready = (state_ff == fsv_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_question    = (req_chan.command == fsv_pkg::CMD_QUESTION);
   assign is_verify      = (req_chan.command == fsv_pkg::CMD_VERIFY);
   assign is_check       = (req_chan.command == fsv_pkg::CMD_CHECK);
   assign go_test        = ((is_verify && pending_ff) || is_check) &&
                           (rounds_ff != '0);

   assign test_pass = (fsv_pkg::DATA_WIDTH'(acc_ff) == x_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // ------------------------------------------------------------------
   // Multiply step: acc = (2*acc + bit*a) mod n, with acc and a below n,
   // so the raw sum stays below 3n and one of two subtractions reduces it.
   // ------------------------------------------------------------------
   always_comb begin
      sum_raw   = {acc_ff, 1'b0} +
                  (mult_b_ff[fsv_pkg::DATA_WIDTH-1] ?
                   fsv_pkg::SUM_WIDTH'(mult_a_ff) : '0);
      mod_once  = fsv_pkg::SUM_WIDTH'(modulus_ff);
      mod_twice = fsv_pkg::SUM_WIDTH'({modulus_ff, 1'b0});
      if (sum_raw >= mod_twice) begin
         step_sum = fsv_pkg::MOD_WIDTH'(sum_raw - mod_twice);
      end else if (sum_raw >= mod_once) begin
         step_sum = fsv_pkg::MOD_WIDTH'(sum_raw - mod_once);
      end else begin
         step_sum = fsv_pkg::MOD_WIDTH'(sum_raw);
      end
   end

   assign last_bit = (cnt_ff == fsv_pkg::CNT_WIDTH'(fsv_pkg::DATA_WIDTH - 1));

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsv_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = go_test ? fsv_pkg::ST_REDUCE : fsv_pkg::ST_DONE;
            end
         end
         fsv_pkg::ST_REDUCE: begin
            if (last_bit) begin
               state_in = fsv_pkg::ST_SQUARE;
            end
         end
         fsv_pkg::ST_SQUARE: begin
            if (last_bit) begin
               state_in = bit_ff ? fsv_pkg::ST_KEY : fsv_pkg::ST_CHECK;
            end
         end
         fsv_pkg::ST_KEY: begin
            if (last_bit) begin
               state_in = fsv_pkg::ST_CHECK;
            end
         end
         fsv_pkg::ST_CHECK: begin
            state_in = fsv_pkg::ST_DONE;
         end
         fsv_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fsv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fsv_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         fsv_pkg::ST_IDLE: begin
            ctl.unit_start = req_fire && go_test;
         end
         fsv_pkg::ST_REDUCE: begin
            ctl.unit_step    = 1'b1;
            ctl.chain_square = last_bit;
         end
         fsv_pkg::ST_SQUARE: begin
            ctl.unit_step = 1'b1;
            ctl.chain_key = last_bit && bit_ff;
         end
         fsv_pkg::ST_KEY: begin
            ctl.unit_step = 1'b1;
         end
         fsv_pkg::ST_CHECK: begin
            ctl.check_en = 1'b1;
         end
         fsv_pkg::ST_DONE: begin
            ctl.post = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = fsv_pkg::csr_index_type'(
                          csr_paddr[fsv_pkg::CSR_ADDR_WIDTH-1:fsv_pkg::CSR_INDEX_LSB]);

   always_comb begin
      round_wr   = csr_pwdata[fsv_pkg::ROUND_WIDTH-1:0];
      modulus_wr = csr_pwdata[fsv_pkg::MOD_WIDTH-1:0];
      if (!(round_wr inside {[fsv_pkg::ROUNDS_MIN:fsv_pkg::ROUNDS_MAX]})) begin
         round_wr = (round_wr < fsv_pkg::ROUNDS_MIN) ? fsv_pkg::ROUNDS_MIN
                                                    : fsv_pkg::ROUNDS_MAX;
      end
      // A modulus of zero or one would leave nothing to reduce into.
      if (modulus_wr < fsv_pkg::MODULUS_RESET) begin
         modulus_wr = fsv_pkg::MODULUS_RESET;
      end
   end

   always_comb begin
      case (csr_index)
         fsv_pkg::CSR_MODULUS:     csr_prdata = fsv_pkg::CSR_DATA_WIDTH'(modulus_ff);
         fsv_pkg::CSR_PUBLIC_KEY:  csr_prdata = fsv_pkg::CSR_DATA_WIDTH'(public_key_ff);
         fsv_pkg::CSR_ROUND_COUNT: csr_prdata = fsv_pkg::CSR_DATA_WIDTH'(round_count_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= fsv_pkg::ST_IDLE;
         modulus_ff           <= fsv_pkg::MODULUS_RESET;
         public_key_ff        <= fsv_pkg::PUBLIC_KEY_RESET;
         round_count_ff       <= fsv_pkg::ROUNDS_MIN;
         rounds_ff            <= fsv_pkg::ROUNDS_MIN;
         pending_ff           <= 1'b0;
         stored_commitment_ff <= '0;
         stored_challenge_ff  <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_write) begin
            case (csr_index)
               fsv_pkg::CSR_MODULUS: begin
                  modulus_ff <= modulus_wr;
                  rounds_ff  <= round_count_ff;
               end
               fsv_pkg::CSR_PUBLIC_KEY: begin
                  public_key_ff <= csr_pwdata[fsv_pkg::MOD_WIDTH-1:0];
                  rounds_ff     <= round_count_ff;
               end
               fsv_pkg::CSR_ROUND_COUNT: begin
                  round_count_ff <= round_wr;
                  rounds_ff      <= round_wr;
               end
               default: begin
               end
            endcase
         end else if (ctl.check_en) begin
            rounds_ff <= test_pass ? rounds_ff - fsv_pkg::ROUND_WIDTH'(1)
                                   : round_count_ff;
         end

         if (req_fire) begin
            if (is_question) begin
               if (!pending_ff) begin
                  pending_ff           <= 1'b1;
                  stored_commitment_ff <= req_chan.commitment;
                  stored_challenge_ff  <= req_chan.challenge_bit;
               end
            end else if (is_verify || is_check) begin
               // Any test closes the open question, even one that errors out.
               pending_ff <= 1'b0;
            end
         end

         if (ctl.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_ff   <= is_verify ? stored_commitment_ff : req_chan.commitment;
         bit_ff <= is_verify ? stored_challenge_ff : req_chan.challenge_bit;
         y_ff   <= req_chan.response;

         res_ok_ff   <= is_question && !pending_ff;
         res_chal_ff <= is_question && !pending_ff && req_chan.challenge_bit;
         res_left_ff <= rounds_ff;
      end

      if (ctl.check_en) begin
         res_ok_ff   <= test_pass;
         res_chal_ff <= 1'b0;
         res_left_ff <= test_pass ? rounds_ff - fsv_pkg::ROUND_WIDTH'(1) : rounds_ff;
      end

      // First pass multiplies 1 by y, which leaves y mod n in the accumulator.
      if (ctl.unit_start) begin
         acc_ff    <= '0;
         mult_a_ff <= fsv_pkg::MOD_WIDTH'(1);
         mult_b_ff <= req_chan.response;
         cnt_ff    <= '0;
      end else if (ctl.unit_step) begin
         cnt_ff <= cnt_ff + fsv_pkg::CNT_WIDTH'(1);
         if (ctl.chain_square) begin
            acc_ff    <= '0;
            mult_a_ff <= step_sum;
            mult_b_ff <= y_ff;
         end else if (ctl.chain_key) begin
            acc_ff    <= '0;
            mult_a_ff <= step_sum;
            mult_b_ff <= fsv_pkg::DATA_WIDTH'(public_key_ff);
         end else begin
            acc_ff    <= step_sum;
            mult_b_ff <= {mult_b_ff[fsv_pkg::DATA_WIDTH-2:0], 1'b0};
         end
      end

      if (ctl.post) begin
         rsp_success_ff <= res_ok_ff;
         rsp_chal_ff    <= res_chal_ff;
         rsp_left_ff    <= res_left_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.success       = rsp_success_ff;
   assign rsp_chan.challenge_out = rsp_chal_ff;
   assign rsp_chan.rounds_left   = rsp_left_ff;

`ifndef SYNTHESIS
   a_rounds_bounded : assert property (@(posedge clock) disable iff (reset)
      rounds_ff <= fsv_pkg::ROUNDS_MAX)
      else $error("round counter above its maximum");

   a_unit_reduced : assert property (@(posedge clock) disable iff (reset)
      (state_ff == fsv_pkg::ST_REDUCE || state_ff == fsv_pkg::ST_SQUARE ||
       state_ff == fsv_pkg::ST_KEY || state_ff == fsv_pkg::ST_CHECK)
      |-> (acc_ff < modulus_ff) && (mult_a_ff < modulus_ff))
      else $error("multiply operands not reduced below the modulus");

   a_start_clean : assert property (@(posedge clock) disable iff (reset)
      ctl.unit_start |=> (state_ff == fsv_pkg::ST_REDUCE) && (cnt_ff == '0))
      else $error("test did not start with a cleared bit counter");

   a_fail_reloads : assert property (@(posedge clock) disable iff (reset)
      ctl.check_en && !test_pass |=> rounds_ff == round_count_ff)
      else $error("failed test did not reload the round counter");

   a_chal_implies_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.challenge_out |-> rsp_chan.success)
      else $error("challenge issued on a refused beat");
`endif

endmodule

`default_nettype wire
